// ----- design/ccx_pkg.sv -----
`default_nettype none
package ccx_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] state_t;

  typedef enum logic [2:0] {
    REG_KEY_A   = 3'd0,
    REG_KEY_B   = 3'd1,
    REG_KEY_C   = 3'd2,
    REG_KEY_D   = 3'd3,
    REG_NONCE_L = 3'd4,
    REG_NONCE_H = 3'd5,
    REG_COUNTER = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } core_ctl_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction
endpackage
`default_nettype wire

// ----- design/ccx_stream_if.sv -----
`default_nettype none
interface ccx_stream_if #(parameter int W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  logic [3:0]   count;
  logic         last;
  modport source (output valid, data, count, last, input ready);
  modport sink (input valid, data, count, last, output ready);
endinterface
`default_nettype wire

// ----- design/ccx_qround.sv -----
`default_nettype none
module ccx_qround import ccx_pkg::*; (
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic [31:0] c_i,
  input  wire logic [31:0] d_i,
  input  wire logic        half_i,
  output logic [31:0]      a_o,
  output logic [31:0]      b_o,
  output logic [31:0]      c_o,
  output logic [31:0]      d_o
);
  // one half quarter-round per cycle: rotations 16/12, or 8/7
  logic [31:0] a1, d1, c1, b1;
  always_comb begin
    a1 = a_i + b_i;
    d1 = half_i ? rotl(d_i ^ a1, 8) : rotl(d_i ^ a1, 16);
    c1 = c_i + d1;
    b1 = half_i ? rotl(b_i ^ c1, 7) : rotl(b_i ^ c1, 12);
    a_o = a1;
    b_o = b1;
    c_o = c1;
    d_o = d1;
  end
endmodule
`default_nettype wire

// ----- design/ccx_core.sv -----
`default_nettype none
module ccx_core import ccx_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   start_i,
  input  wire state_t init_i,
  output logic        done_o,
  output state_t      block_o
);
  localparam int STEPS = DOUBLE_ROUNDS * 4;
  localparam int SW = $clog2(STEPS + 1);

  state_t      w_q, w_d, init_q;
  logic [SW-1:0] step_q;
  logic        busy_q, done_q;
  logic        diag, half;
  logic [3:0][31:0] la, lb, lc, ld, oa, ob, oc, od;

  assign half = step_q[0];
  assign diag = step_q[1];

  // four lanes; diagonal steps pick words by rotated index
  for (genvar l = 0; l < 4; l++) begin : g_lane
    localparam int B0 = 4 + l;
    localparam int C0 = 8 + l;
    localparam int D0 = 12 + l;
    localparam int B1 = 4 + ((l + 1) % 4);
    localparam int C1 = 8 + ((l + 2) % 4);
    localparam int D1 = 12 + ((l + 3) % 4);
    assign la[l] = w_q[l];
    assign lb[l] = diag ? w_q[B1] : w_q[B0];
    assign lc[l] = diag ? w_q[C1] : w_q[C0];
    assign ld[l] = diag ? w_q[D1] : w_q[D0];
    ccx_qround u_qr (
      .a_i(la[l]), .b_i(lb[l]), .c_i(lc[l]), .d_i(ld[l]), .half_i(half),
      .a_o(oa[l]), .b_o(ob[l]), .c_o(oc[l]), .d_o(od[l])
    );
  end

  always_comb begin
    w_d = w_q;
    for (int l = 0; l < 4; l++) begin
      w_d[l] = oa[l];
      if (diag) begin
        w_d[4 + ((l + 1) % 4)]  = ob[l];
        w_d[8 + ((l + 2) % 4)]  = oc[l];
        w_d[12 + ((l + 3) % 4)] = od[l];
      end else begin
        w_d[4 + l]  = ob[l];
        w_d[8 + l]  = oc[l];
        w_d[12 + l] = od[l];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == SW'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      w_q    <= init_i;
      init_q <= init_i;
    end else if (busy_q) begin
      w_q <= w_d;
    end
  end

  // feed-forward add
  always_comb begin
    for (int i = 0; i < 16; i++) block_o[i] = w_q[i] + init_q[i];
  end
  assign done_o = done_q;
endmodule
`default_nettype wire

// ----- design/stream_cipher_keystream_xor.sv -----
// Chunks that find keystream held are XORed without waiting for the core; a
// chunk needing a fresh block waits while the core runs all its rounds.
// Each block gives keystream for up to eight chunks; the rate of fresh blocks is
// set by the four-lane core taking half a quarter-round per cycle.
// Reset: no keystream held, word position 0, counter 1, key and nonce 0.
`default_nettype none
module stream_cipher_keystream_xor import ccx_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  ccx_stream_if.sink       in_if,
  ccx_stream_if.source     out_if,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);
  logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q, nonce_l_q;
  logic [31:0] nonce_h_q, init_ctr_q, ctr_q;
  logic [7:0][63:0] ks_q;
  logic [2:0]  pos_q;
  logic        ready_q;
  ctrl_state_e st_q, st_d;
  logic [63:0] dout_q, dat_q;
  logic [3:0]  cnt_q;
  logic        last_q;
  logic        core_done, start, accept, wr;
  state_t      init_st, blk;
  reg_idx_e    widx;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;
  assign widx = reg_idx_e'(paddr[5:3]);

  always_comb begin
    case (widx)
      REG_KEY_A:   prdata = key_a_q;
      REG_KEY_B:   prdata = key_b_q;
      REG_KEY_C:   prdata = key_c_q;
      REG_KEY_D:   prdata = key_d_q;
      REG_NONCE_L: prdata = nonce_l_q;
      REG_NONCE_H: prdata = {32'd0, nonce_h_q};
      REG_COUNTER: prdata = {32'd0, init_ctr_q};
      default:     prdata = '0;
    endcase
  end

  assign init_st = {nonce_h_q, nonce_l_q[63:32], nonce_l_q[31:0], ctr_q,
                    key_d_q[63:32], key_d_q[31:0], key_c_q[63:32], key_c_q[31:0],
                    key_b_q[63:32], key_b_q[31:0], key_a_q[63:32], key_a_q[31:0],
                    SIGMA3, SIGMA2, SIGMA1, SIGMA0};

  ccx_core #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_core (
    .clk_i, .rst_ni, .start_i(start), .init_i(init_st),
    .done_o(core_done), .block_o(blk)
  );

  // ST_IDLE: waiting for a word; ST_ROUND: block in flight; ST_OUT: result held
  assign in_if.ready = (st_q == ST_IDLE) || (st_q == ST_OUT && out_if.ready);
  assign accept = in_if.valid && in_if.ready;
  assign start = accept && !ready_q;
  assign out_if.valid = (st_q == ST_OUT);
  assign out_if.data  = dout_q;
  assign out_if.count = cnt_q;
  assign out_if.last  = last_q;

  // word being processed: held copy once a block is in flight, else the input
  logic [63:0] cur_dat;
  logic [3:0]  cur_cnt;
  logic        cur_last;
  assign cur_dat  = (st_q == ST_ROUND) ? dat_q  : in_if.data;
  assign cur_cnt  = (st_q == ST_ROUND) ? cnt_q  : in_if.count;
  assign cur_last = (st_q == ST_ROUND) ? last_q : in_if.last;

  logic [63:0] mask_in, ks_word;
  always_comb begin
    mask_in = '1;
    if (cur_cnt < 4'd8) mask_in = (64'd1 << {cur_cnt[2:0], 3'b000}) - 64'd1;
  end
  assign ks_word = ready_q ? ks_q[pos_q] : {blk[1], blk[0]};

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:  if (accept) st_d = ready_q ? ST_OUT : ST_ROUND;
      ST_ROUND: if (core_done) st_d = ST_OUT;
      ST_OUT: begin
        if (accept) st_d = ready_q ? ST_OUT : ST_ROUND;
        else if (out_if.ready) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  logic use_now;
  assign use_now = (accept && ready_q) || (st_q == ST_ROUND && core_done);

  // current word index in use: fresh block starts at zero
  function automatic logic [2:0] pos_q_next(input logic rdy, input logic [2:0] p);
    return rdy ? p : 3'd0;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      key_a_q <= '0; key_b_q <= '0; key_c_q <= '0; key_d_q <= '0;
      nonce_l_q <= '0; nonce_h_q <= '0;
      init_ctr_q <= 32'd1;
      ctr_q <= 32'd1;
      pos_q <= '0;
      ready_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (start && !(wr && widx == REG_COUNTER)) ctr_q <= ctr_q + 32'd1;
      if (wr) begin
        case (widx)
          REG_KEY_A:   key_a_q <= pwdata;
          REG_KEY_B:   key_b_q <= pwdata;
          REG_KEY_C:   key_c_q <= pwdata;
          REG_KEY_D:   key_d_q <= pwdata;
          REG_NONCE_L: nonce_l_q <= pwdata;
          REG_NONCE_H: nonce_h_q <= pwdata[31:0];
          REG_COUNTER: begin
            init_ctr_q <= pwdata[31:0];
            ctr_q      <= pwdata[31:0];
          end
          default: ;
        endcase
      end
      if (use_now) begin
        if (cur_last || &pos_q_next(ready_q, pos_q)) begin
          ready_q <= 1'b0;
          pos_q   <= '0;
        end else begin
          ready_q <= 1'b1;
          pos_q   <= pos_q_next(ready_q, pos_q) + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dat_q  <= in_if.data;
      cnt_q  <= in_if.count;
      last_q <= in_if.last;
    end
    if (st_q == ST_ROUND && core_done) begin
      for (int i = 0; i < 8; i++) ks_q[i] <= {blk[2*i+1], blk[2*i]};
    end
    if (use_now) dout_q <= (cur_dat ^ ks_word) & mask_in;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ROUND) |-> !out_if.valid) else $error("result shown during round");
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_ROUND) |-> !in_if.ready) else $error("input taken while busy");
  a_ctr_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !wr) |=> ctr_q == $past(ctr_q) + 32'd1) else $error("counter step");
endmodule
`default_nettype wire
